// File: rtl/nsq_pkg.sv
// Shared types, codes and constants of the notification slot and waiting queue.
package nsq_pkg;

   // Default number of waiting queue entries.
   localparam int QueueDepthDefault = 4;
   // Width of the waiting count field of a response.
   localparam int WaitCountWidth = 3;

   typedef enum logic [2:0] {
      KIND_PUSH         = 3'd0,
      KIND_DISMISS      = 3'd1,
      KIND_MEDIA_STATE  = 3'd2,
      KIND_SWIPE        = 3'd3,
      KIND_ACCEPT       = 3'd4,
      KIND_REJECT       = 3'd5,
      KIND_END_CALL     = 3'd6,
      KIND_MEDIA_ACTION = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_DISMISS    = 3'd1,
      CMD_ACCEPT     = 3'd2,
      CMD_REJECT     = 3'd3,
      CMD_END        = 3'd4,
      CMD_PREV       = 3'd5,
      CMD_PLAY_PAUSE = 3'd6,
      CMD_NEXT       = 3'd7
   } cmd_type;

   // Media state codes.
   localparam logic [1:0] MEDIA_STOPPED = 2'd0;
   localparam logic [1:0] MEDIA_PLAYING = 2'd1;
   localparam logic [1:0] MEDIA_PAUSED  = 2'd2;

   // Swipe direction codes.
   localparam logic [1:0] SWIPE_UP   = 2'd0;
   localparam logic [1:0] SWIPE_DOWN = 2'd1;

   // Media action codes; the fourth code has no meaning.
   localparam logic [1:0] ACTION_PREV       = 2'd0;
   localparam logic [1:0] ACTION_PLAY_PAUSE = 2'd1;
   localparam logic [1:0] ACTION_NEXT       = 2'd2;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] note_id;
      logic        note_is_call;
      logic [15:0] note_handle;
      logic [1:0]  media_state_in;
      logic [1:0]  swipe_dir;
      logic [1:0]  media_action;
      logic [31:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      cmd_type                   command;
      logic [31:0]               command_id;
      logic                      slot_active;
      logic [31:0]               slot_id;
      logic                      slot_is_call;
      logic [15:0]               slot_handle;
      logic                      call_running;
      logic [31:0]               call_start;
      logic [WaitCountWidth-1:0] waiting_count;
      logic                      banner_shown;
      logic [1:0]                media_state_out;
   } rsp_payload_type;

   // Controller sequencing states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_OUTPUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic apply;
      logic scan_start;
      logic scan_next;
      logic scan_drop;
      logic scan_miss;
      logic publish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_needed;
      logic scan_hit;
      logic scan_done;
      logic out_free;
   } ctrl_status_type;

endpackage

// File: rtl/nsq_chan_if.sv
// Valid/ready channel interface used for the request and response channels.
interface nsq_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/notification_slot_with_priority_queue.sv
// Top level of the notification slot with its bounded waiting queue.
//
// Requests arrive on req_chan (valid/ready); each one yields exactly one
// response on rsp_chan that carries the command code and the full slot,
// queue and media state after the request.
// A request is taken only while the block is idle. A push into a full
// queue and a dismiss of an id that is not in the slot search the queue
// one entry per cycle; every other request needs no queue search.
// The response sits in an output register; a stalled receiver holds it
// there while the next request is already being worked on, and only the
// completion of that next request waits for the register to drain.
// Synchronous reset empties the slot and queue, clears the banner, sets
// the media state to stopped and drops any pending response.
module notification_slot_with_priority_queue
   import nsq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input logic            clock,
   input logic            reset,
   nsq_chan_if.sink       req_chan,
   nsq_chan_if.source     rsp_chan
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   rsp_payload_type rsp_data;

   nsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nsq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_chan.payload),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_data;

endmodule

// File: rtl/nsq_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module nsq_ctrl
   import nsq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.scan_needed) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               cmd.apply = 1'b1;
               state_in  = ST_OUTPUT;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               cmd.scan_miss = 1'b1;
               state_in      = ST_OUTPUT;
            end else if (status.scan_hit) begin
               cmd.scan_drop = 1'b1;
               state_in      = ST_OUTPUT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/nsq_dp.sv
// Datapath: shown slot, waiting queue, media flags and the response register.
module nsq_dp
   import nsq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [CW-1:0] DepthCount = CW'(QUEUE_DEPTH);

   req_payload_type req_ff, req_in;
   logic            active_valid_ff, active_valid_in;
   logic [31:0]     active_ident_ff, active_ident_in;
   logic            active_call_ff, active_call_in;
   logic [15:0]     active_ref_ff, active_ref_in;
   logic            in_progress_ff, in_progress_in;
   logic [31:0]     start_tick_ff, start_tick_in;
   logic [31:0]     q_ident_ff [QUEUE_DEPTH];
   logic [31:0]     q_ident_in [QUEUE_DEPTH];
   logic            q_call_ff [QUEUE_DEPTH];
   logic            q_call_in [QUEUE_DEPTH];
   logic [15:0]     q_ref_ff [QUEUE_DEPTH];
   logic [15:0]     q_ref_in [QUEUE_DEPTH];
   logic [CW-1:0]   fill_ff, fill_in;
   logic            banner_ff, banner_in;
   logic [1:0]      media_ff, media_in;
   cmd_type         cmd_code_ff, cmd_code_in;
   logic [31:0]     cmd_id_ff, cmd_id_in;
   logic [CW-1:0]   scan_idx_ff, scan_idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            active_match;
   logic            do_advance;
   logic            do_drop;
   logic            do_append;
   logic [CW-1:0]   drop_pos;
   logic [CW-1:0]   append_pos;
   logic [IW-1:0]   scan_rd;
   logic            media_shown;

   // Status toward the controller; the scan reads one queue entry a cycle.
   assign active_match = active_valid_ff && (active_ident_ff == req_ff.note_id);
   assign scan_rd      = scan_idx_ff[IW-1:0];
   assign media_shown  = (media_ff == MEDIA_PLAYING) || (media_ff == MEDIA_PAUSED);

   always_comb begin
      status.scan_needed = ((req_ff.kind == KIND_PUSH) && active_valid_ff &&
                            (fill_ff >= DepthCount)) ||
                           ((req_ff.kind == KIND_DISMISS) && !active_match);
      status.scan_done   = (scan_idx_ff >= fill_ff);
      status.scan_hit    = 1'b0;
      if (!status.scan_done) begin
         if (req_ff.kind == KIND_PUSH) begin
            status.scan_hit = !q_call_ff[scan_rd];
         end else begin
            status.scan_hit = (q_ident_ff[scan_rd] == req_ff.note_id);
         end
      end
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   // Next state of the slot, queue and flags.
   always_comb begin
      req_in          = req_ff;
      active_valid_in = active_valid_ff;
      active_ident_in = active_ident_ff;
      active_call_in  = active_call_ff;
      active_ref_in   = active_ref_ff;
      in_progress_in  = in_progress_ff;
      start_tick_in   = start_tick_ff;
      q_ident_in      = q_ident_ff;
      q_call_in       = q_call_ff;
      q_ref_in        = q_ref_ff;
      fill_in         = fill_ff;
      banner_in       = banner_ff;
      media_in        = media_ff;
      cmd_code_in     = cmd_code_ff;
      cmd_id_in       = cmd_id_ff;
      scan_idx_in     = scan_idx_ff;
      do_advance      = 1'b0;
      do_drop         = 1'b0;
      do_append       = 1'b0;
      drop_pos        = '0;
      append_pos      = fill_ff;

      if (cmd.capture) begin
         req_in      = req_data;
         cmd_code_in = CMD_NONE;
         cmd_id_in   = '0;
      end
      if (cmd.scan_start) begin
         scan_idx_in = '0;
      end
      if (cmd.scan_next) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      // Requests that finish without a queue search.
      if (cmd.apply) begin
         case (req_ff.kind)
            KIND_PUSH: begin
               banner_in = 1'b0;
               if (!active_valid_ff) begin
                  active_valid_in = 1'b1;
                  active_ident_in = req_ff.note_id;
                  active_call_in  = req_ff.note_is_call;
                  active_ref_in   = req_ff.note_handle;
                  in_progress_in  = 1'b0;
                  start_tick_in   = '0;
               end else begin
                  do_append = 1'b1;
                  fill_in   = fill_ff + 1'b1;
               end
            end
            KIND_DISMISS: begin
               do_advance = active_match;
            end
            KIND_MEDIA_STATE: begin
               media_in = req_ff.media_state_in;
               if ((req_ff.media_state_in != MEDIA_PLAYING) &&
                   (req_ff.media_state_in != MEDIA_PAUSED)) begin
                  banner_in = 1'b0;
               end
            end
            KIND_SWIPE: begin
               if (active_valid_ff) begin
                  if (!active_call_ff) begin
                     cmd_code_in = CMD_DISMISS;
                     cmd_id_in   = active_ident_ff;
                     do_advance  = 1'b1;
                  end
               end else if (req_ff.swipe_dir == SWIPE_UP) begin
                  if (media_shown) begin
                     banner_in = 1'b1;
                  end
               end else if (req_ff.swipe_dir == SWIPE_DOWN) begin
                  banner_in = 1'b0;
               end
            end
            KIND_ACCEPT: begin
               if (active_valid_ff && active_call_ff && !in_progress_ff) begin
                  in_progress_in = 1'b1;
                  start_tick_in  = req_ff.now_ms;
                  cmd_code_in    = CMD_ACCEPT;
               end
            end
            KIND_REJECT: begin
               if (active_valid_ff && active_call_ff) begin
                  do_advance  = 1'b1;
                  cmd_code_in = CMD_REJECT;
               end
            end
            KIND_END_CALL: begin
               if (active_valid_ff && active_call_ff && in_progress_ff) begin
                  do_advance  = 1'b1;
                  cmd_code_in = CMD_END;
               end
            end
            KIND_MEDIA_ACTION: begin
               case (req_ff.media_action)
                  ACTION_PREV:       cmd_code_in = CMD_PREV;
                  ACTION_PLAY_PAUSE: cmd_code_in = CMD_PLAY_PAUSE;
                  ACTION_NEXT:       cmd_code_in = CMD_NEXT;
                  default:           cmd_code_in = CMD_NONE;
               endcase
            end
            default: begin
               cmd_code_in = CMD_NONE;
            end
         endcase
      end

      // End of a search: a hit removes the entry, and a push then takes the tail.
      if (cmd.scan_drop) begin
         do_drop  = 1'b1;
         drop_pos = scan_idx_ff;
         if (req_ff.kind == KIND_PUSH) begin
            banner_in  = 1'b0;
            do_append  = 1'b1;
            append_pos = fill_ff - 1'b1;
         end else begin
            fill_in = fill_ff - 1'b1;
         end
      end
      if (cmd.scan_miss && (req_ff.kind == KIND_PUSH)) begin
         banner_in = 1'b0;
      end

      // Promote the queue head into the slot, or clear the slot.
      if (do_advance) begin
         in_progress_in = 1'b0;
         start_tick_in  = '0;
         if (fill_ff != '0) begin
            active_valid_in = 1'b1;
            active_ident_in = q_ident_ff[0];
            active_call_in  = q_call_ff[0];
            active_ref_in   = q_ref_ff[0];
            do_drop         = 1'b1;
            drop_pos        = '0;
            fill_in         = fill_ff - 1'b1;
         end else begin
            active_valid_in = 1'b0;
            active_ident_in = '0;
            active_call_in  = 1'b0;
            active_ref_in   = '0;
         end
      end

      // Close the gap behind a removed entry.
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
         if (do_drop && (CW'(j) >= drop_pos) && (CW'(j + 1) < fill_ff)) begin
            q_ident_in[j] = q_ident_ff[j + 1];
            q_call_in[j]  = q_call_ff[j + 1];
            q_ref_in[j]   = q_ref_ff[j + 1];
         end
      end
      if (do_append) begin
         q_ident_in[append_pos[IW-1:0]] = req_ff.note_id;
         q_call_in[append_pos[IW-1:0]]  = req_ff.note_is_call;
         q_ref_in[append_pos[IW-1:0]]   = req_ff.note_handle;
      end
   end

   // Response register: loaded once a request is done, held while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.publish) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.command         = cmd_code_ff;
         rsp_data_in.command_id      = cmd_id_ff;
         rsp_data_in.slot_active     = active_valid_ff;
         rsp_data_in.slot_id         = active_ident_ff;
         rsp_data_in.slot_is_call    = active_call_ff;
         rsp_data_in.slot_handle     = active_ref_ff;
         rsp_data_in.call_running    = in_progress_ff;
         rsp_data_in.call_start      = start_tick_ff;
         rsp_data_in.waiting_count   = WaitCountWidth'(fill_ff);
         rsp_data_in.banner_shown    = banner_ff;
         rsp_data_in.media_state_out = media_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State that reset clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_valid_ff <= 1'b0;
         active_ident_ff <= '0;
         active_call_ff  <= 1'b0;
         active_ref_ff   <= '0;
         in_progress_ff  <= 1'b0;
         start_tick_ff   <= '0;
         fill_ff         <= '0;
         banner_ff       <= 1'b0;
         media_ff        <= MEDIA_STOPPED;
         rsp_valid_ff    <= 1'b0;
      end else begin
         active_valid_ff <= active_valid_in;
         active_ident_ff <= active_ident_in;
         active_call_ff  <= active_call_in;
         active_ref_ff   <= active_ref_in;
         in_progress_ff  <= in_progress_in;
         start_tick_ff   <= start_tick_in;
         fill_ff         <= fill_in;
         banner_ff       <= banner_in;
         media_ff        <= media_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      q_ident_ff  <= q_ident_in;
      q_call_ff   <= q_call_in;
      q_ref_ff    <= q_ref_in;
      cmd_code_ff <= cmd_code_in;
      cmd_id_ff   <= cmd_id_in;
      scan_idx_ff <= scan_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/nsq_checker.sv
// Port-level assertions for the notification slot block and their binding.
module nsq_checker
   import nsq_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A stalled response stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // An empty slot shows all-zero slot and call fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.slot_active |->
         rsp_data.slot_id == '0 && !rsp_data.slot_is_call &&
         rsp_data.slot_handle == '0 && !rsp_data.call_running &&
         rsp_data.call_start == '0)
      else $error("empty slot shows stale contents");

   // A running call is always a shown call.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.call_running |->
         rsp_data.slot_active && rsp_data.slot_is_call)
      else $error("call running without a shown call");

   // Entries wait only behind a shown entry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.waiting_count != '0 |-> rsp_data.slot_active)
      else $error("queue holds entries while the slot is empty");

   // Only a dismiss command carries an id.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.command != CMD_DISMISS |-> rsp_data.command_id == '0)
      else $error("id given with a command other than dismiss");

endmodule

bind notification_slot_with_priority_queue nsq_checker u_nsq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.payload)
);
